### hdl/stfd_pkg.sv
// ----------------------------------------------------------------------------
// stfd_pkg
// Shared constants and types for the share target from difficulty unit.
// ----------------------------------------------------------------------------
package stfd_pkg;

  // Word and target geometry
  localparam int WORD_W     = 64;
  localparam int NUM_WORDS  = 4;
  localparam int TARGET_W   = WORD_W * NUM_WORDS;
  localparam int IDX_W      = $clog2(NUM_WORDS);
  localparam int DIV_STEP_W = $clog2(TARGET_W);
  localparam int MUL_W      = 32;
  localparam int MUL_STEP_W = $clog2(MUL_W);

  // Output tdata: target word, then word index, padded to whole bytes
  localparam int OUT_FIELD_W = WORD_W + IDX_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // Difficulty is given in units of 1e-8
  localparam logic [WORD_W-1:0] SCALE_UNITS = 64'd100000000;

  // Saturation fill
  localparam logic [7:0] SAT_BYTE = 8'hff;
  localparam logic [TARGET_W-1:0] TARGET_SAT = {(TARGET_W / 8){SAT_BYTE}};

  // Difficulty-1 target: 0xffff shifted left by 208 bits
  localparam logic [TARGET_W-1:0] DIFF1 =
    {64'h0000_0000_ffff_0000, {(TARGET_W - WORD_W){1'b0}}};

  // Last word position
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WORDS - 1);

  // Status returned by the shift-add multiplier
  typedef struct packed {
    logic done;
    logic overflow;
  } mul_stat_t;

endpackage

### hdl/stfd_div.sv
// ----------------------------------------------------------------------------
// stfd_div
// Bit-serial restoring divider: 256-bit dividend by 64-bit divisor, one
// quotient bit per cycle, MSB first. Done pulses once both results hold.
// ----------------------------------------------------------------------------
module stfd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [stfd_pkg::TARGET_W-1:0] dividend,
  input  logic [stfd_pkg::WORD_W-1:0]   divisor,
  output logic                          done,
  output logic [stfd_pkg::TARGET_W-1:0] quotient,
  output logic [stfd_pkg::WORD_W-1:0]   remainder
);
  import stfd_pkg::*;

  logic                  busy;
  logic [DIV_STEP_W-1:0] step;
  logic [WORD_W-1:0]     dsr;
  logic [WORD_W:0]       trial;
  logic [WORD_W:0]       diff;
  logic                  ge;

  // Partial remainder with next dividend bit brought down
  always_comb begin
    trial = {remainder, quotient[TARGET_W-1]};
    diff  = trial - {1'b0, dsr};
    ge    = (trial >= {1'b0, dsr});
  end

  // Sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '1;
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in from the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[TARGET_W-2:0], ge};
      remainder <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
    end
  end

endmodule

### hdl/stfd_mul.sv
// ----------------------------------------------------------------------------
// stfd_mul
// Shift-add multiplier: 256-bit multiplicand by 32-bit multiplier, one
// multiplier bit per cycle, MSB first, with a sticky overflow flag.
// ----------------------------------------------------------------------------
module stfd_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [stfd_pkg::TARGET_W-1:0] multiplicand,
  input  logic [stfd_pkg::MUL_W-1:0]    multiplier,
  output stfd_pkg::mul_stat_t           stat,
  output logic [stfd_pkg::TARGET_W-1:0] product
);
  import stfd_pkg::*;

  logic                  busy;
  logic                  done;
  logic                  overflow;
  logic [MUL_STEP_W-1:0] step;
  logic [TARGET_W-1:0]   mcand;
  logic [MUL_W-1:0]      mplier;
  logic [TARGET_W+1:0]   sum;

  // acc*2 + (bit ? a : 0); anything above bit 255 is overflow
  always_comb begin
    sum = {1'b0, product, 1'b0} + {2'b00, (mplier[MUL_W-1] ? mcand : '0)};
  end

  // Status out
  assign stat = '{done: done, overflow: overflow};

  // Sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '1;
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      product  <= '0;
      mcand    <= multiplicand;
      mplier   <= multiplier;
      overflow <= 1'b0;
    end else if (busy) begin
      product  <= sum[TARGET_W-1:0];
      mplier   <= {mplier[MUL_W-2:0], 1'b0};
      overflow <= overflow | (|sum[TARGET_W+1:TARGET_W]);
    end
  end

endmodule

### hdl/share_target_from_difficulty_unit.sv
// ----------------------------------------------------------------------------
// share_target_from_difficulty_unit
// Converts a scaled pool difficulty into a 256-bit share target.
// ----------------------------------------------------------------------------
// One difficulty (units of 1e-8) is taken per transaction on the slave side;
// the target then leaves as four 64-bit words, most significant first, the
// last one flagged on tlast. Zero returns the difficulty-1 target in the next
// cycle. A difficulty above 1e8 costs one 256-step division and one 32-step
// multiply. One at or below 1e8 costs a 256-step division for the scale
// factor and a 32-step multiply; unless that multiply overflows or the
// difficulty divides 1e8 evenly, a second 32-step multiply, a second 256-step
// division and a final add follow. The four words then go out, each as
// m_tready takes it; s_tready is low until the last word has gone.
module share_target_from_difficulty_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [stfd_pkg::WORD_W-1:0]     s_tdata,  // [63:0] difficulty_scaled
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [stfd_pkg::OUT_DATA_W-1:0] m_tdata,  // [63:0] target_word,
                                                    // [65:64] word_index
  output logic                            m_tlast   // last_word
);
  import stfd_pkg::*;

  typedef enum logic [3:0] {
    IDLE, DIV_SCALE, MUL_FACTOR, MUL_FRAC, DIV_FRAC, DIV_DIFF, MUL_SCALE, SEND
  } state_t;

  state_t              state;
  logic [WORD_W-1:0]   n;
  logic [MUL_W-1:0]    frac;
  logic [TARGET_W-1:0] t;
  logic [IDX_W-1:0]    idx;

  // Unit operands and starts
  logic                div_start, mul_start;
  logic [TARGET_W-1:0] div_dividend, mul_a;
  logic [WORD_W-1:0]   div_divisor;
  logic [MUL_W-1:0]    mul_m;

  // Unit results
  logic                div_done;
  logic [TARGET_W-1:0] div_quo, mul_prod;
  logic [WORD_W-1:0]   div_rem;
  mul_stat_t           mul_stat;
  logic [TARGET_W:0]   total;
  logic [WORD_W-1:0]   word;

  stfd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  stfd_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (mul_a),
    .multiplier   (mul_m),
    .stat         (mul_stat),
    .product      (mul_prod)
  );

  // Integer part plus fractional term
  assign total = {1'b0, t} + {1'b0, div_quo};

  // Handshake
  assign s_tready = (state == IDLE);
  assign m_tvalid = (state == SEND);
  assign m_tlast  = (idx == LAST_IDX);

  // Word select, most significant first
  always_comb begin
    unique case (idx)
      2'd0:    word = t[4*WORD_W-1:3*WORD_W];
      2'd1:    word = t[3*WORD_W-1:2*WORD_W];
      2'd2:    word = t[2*WORD_W-1:WORD_W];
      default: word = t[WORD_W-1:0];
    endcase
    m_tdata = OUT_DATA_W'({idx, word});
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      idx       <= '0;
      div_start <= 1'b0;
      mul_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      mul_start <= 1'b0;
      unique case (state)
        IDLE: begin
          idx <= '0;
          if (s_tvalid) begin
            n <= s_tdata;
            if (s_tdata == '0) begin
              t     <= DIFF1;
              state <= SEND;
            end else if (s_tdata <= SCALE_UNITS) begin
              div_dividend <= TARGET_W'(SCALE_UNITS);
              div_divisor  <= s_tdata;
              div_start    <= 1'b1;
              state        <= DIV_SCALE;
            end else begin
              div_dividend <= DIFF1;
              div_divisor  <= s_tdata;
              div_start    <= 1'b1;
              state        <= DIV_DIFF;
            end
          end
        end
        DIV_SCALE: begin
          if (div_done) begin
            frac      <= div_rem[MUL_W-1:0];
            mul_a     <= DIFF1;
            mul_m     <= div_quo[MUL_W-1:0];
            mul_start <= 1'b1;
            state     <= MUL_FACTOR;
          end
        end
        MUL_FACTOR: begin
          if (mul_stat.done) begin
            if (mul_stat.overflow) begin
              t     <= TARGET_SAT;
              state <= SEND;
            end else begin
              t <= mul_prod;
              if (frac == '0) begin
                state <= SEND;
              end else begin
                mul_a     <= DIFF1;
                mul_m     <= frac;
                mul_start <= 1'b1;
                state     <= MUL_FRAC;
              end
            end
          end
        end
        MUL_FRAC: begin
          // an overflowing fractional term is dropped, t stands
          if (mul_stat.done) begin
            if (mul_stat.overflow) begin
              state <= SEND;
            end else begin
              div_dividend <= mul_prod;
              div_divisor  <= n;
              div_start    <= 1'b1;
              state        <= DIV_FRAC;
            end
          end
        end
        DIV_FRAC: begin
          if (div_done) begin
            t     <= total[TARGET_W] ? TARGET_SAT : total[TARGET_W-1:0];
            state <= SEND;
          end
        end
        DIV_DIFF: begin
          if (div_done) begin
            mul_a     <= div_quo;
            mul_m     <= SCALE_UNITS[MUL_W-1:0];
            mul_start <= 1'b1;
            state     <= MUL_SCALE;
          end
        end
        MUL_SCALE: begin
          if (mul_stat.done) begin
            t     <= mul_stat.overflow ? TARGET_SAT : mul_prod;
            state <= SEND;
          end
        end
        SEND: begin
          if (m_tready) begin
            idx <= idx + 1'b1;
            if (idx == LAST_IDX) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
